@@ hdl/ir_rbb_pkg.sv @@
`timescale 1ns / 1ps

package ir_rbb_pkg;

    localparam int SAMPLE_W     = 10;
    localparam int Q15_W        = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;
    localparam int ATAN_W       = 22;
    localparam int Z_W          = 27;
    localparam int GAIN_W       = 30;
    localparam int MAG_SHIFT    = 49;
    localparam int RECIP_W      = 16;
    localparam int RECIP_SHIFT  = 19;
    localparam int DEG_W        = 9;
    localparam int MAG10_W      = 11;
    localparam int DIST_W       = 10;
    localparam int DEG_FRAC     = 16;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd1000;
    localparam logic [SAMPLE_W:0]   FULL_WEIGHT     = 11'd1023;
    localparam logic [GAIN_W-1:0]   GAIN_Q30        = 30'd652032874;
    localparam logic [RECIP_W-1:0]  RECIP_TEN       = 16'd52429;
    localparam logic [DEG_W-1:0]    DEG_MAX         = 9'd359;
    localparam logic [MAG10_W-1:0]  DIST_LIMIT      = 11'd1012;
    localparam logic [DIST_W-1:0]   DIST_FLOOR      = 10'h200;
    localparam logic signed [MAG10_W:0] DIST_BASE   = 12'sd500;

    localparam longint TURN_Q16    = 64'sd23592960;
    localparam longint HALF_Q16    = 64'sd11796480;
    localparam longint QUARTER_Q16 = 64'sd5898240;
    localparam longint GAIN_L      = 64'sd652032874;
    localparam longint Q15_MAX     = 64'sd32767;
    localparam longint Q15_MIN     = -64'sd32768;

    typedef struct packed {
        logic [DEG_W-1:0]   deg;
        logic [MAG10_W-1:0] mag10;
    } polar_t;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] a;
        unique case (i)
            5'd0:    a = 22'd2949120;
            5'd1:    a = 22'd1740967;
            5'd2:    a = 22'd919879;
            5'd3:    a = 22'd466945;
            5'd4:    a = 22'd234379;
            5'd5:    a = 22'd117304;
            5'd6:    a = 22'd58666;
            5'd7:    a = 22'd29335;
            5'd8:    a = 22'd14668;
            5'd9:    a = 22'd7334;
            5'd10:   a = 22'd3667;
            5'd11:   a = 22'd1833;
            5'd12:   a = 22'd917;
            5'd13:   a = 22'd458;
            5'd14:   a = 22'd229;
            5'd15:   a = 22'd115;
            5'd16:   a = 22'd57;
            5'd17:   a = 22'd29;
            5'd18:   a = 22'd14;
            5'd19:   a = 22'd7;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic longint to_q15(input longint v);
        longint t;
        t = (v + 64'sd16384) >>> 15;
        if (t > Q15_MAX) t = Q15_MAX;
        if (t < Q15_MIN) t = Q15_MIN;
        return t;
    endfunction

    function automatic logic [2*Q15_W-1:0] unit_vec(input longint ang);
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint q;
        logic signed [Q15_W-1:0] cc;
        logic signed [Q15_W-1:0] ss;
        logic signed [Q15_W-1:0] c;
        logic signed [Q15_W-1:0] s;
        q  = (ang / QUARTER_Q16) % 4;
        r  = ang % QUARTER_Q16;
        cc = 16'sd32767;
        ss = 16'sd0;
        if (r != 0) begin
            x = GAIN_L;
            y = 0;
            z = r;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(atan_q16(STEP_W'(i)));
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(atan_q16(STEP_W'(i)));
                end
            end
            cc = Q15_W'(to_q15(x));
            ss = Q15_W'(to_q15(y));
        end
        if (q == 0) begin
            c = cc;
            s = ss;
        end else if (q == 1) begin
            c = -ss;
            s = cc;
        end else if (q == 2) begin
            c = -cc;
            s = -ss;
        end else begin
            c = ss;
            s = -cc;
        end
        return {c, s};
    endfunction

endpackage

@@ hdl/ir_ring_ball_bearing_estimator.sv @@
`timescale 1ns / 1ps

// Ring infrared ball bearing estimator.
// Input channel s_*: one 10-bit sample per request, sensors in angular order,
// NUM_SENSORS requests make one round. Each sample is taken in the idle state and
// written to the sample memory; the minimum is tracked on the fly.
// Output channel m_*: one result per round (ball_found, bearing_deg, distance).
// After the last sample of a round the input is held off while the result is
// built. No ball: the result is loaded once the output register is free. Otherwise
// the neighbor vectors are read one memory word per cycle (2*NEIGHBOR_SPAN+1 reads),
// then the iterative CORDIC unit takes 20 steps, followed by the magnitude states
// P_NORM, P_MUL_HI, P_RECIP and P_FINISH; a zero sum skips the CORDIC unit.
// Config channel cfg_*: one write sets no_ball_threshold, always ready.
// Reset (aresetn low, synchronous) clears the round position, the minimum,
// the threshold (to 1000) and the output valid flag.
// When the receiver stalls, the result is held in the output register; new
// samples are still accepted, and a finished round waits for the register.

module ir_ring_ball_bearing_estimator #(
    parameter int NUM_SENSORS   = 16,
    parameter int NEIGHBOR_SPAN = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ir_rbb_pkg::SAMPLE_W-1:0]      cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ir_rbb_pkg::SAMPLE_W-1:0]      s_sensor_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_ball_found,
    output logic [ir_rbb_pkg::DEG_W-1:0]         m_bearing_deg,
    output logic signed [ir_rbb_pkg::DIST_W-1:0] m_distance
);

    localparam int AW     = $clog2(NUM_SENSORS);
    localparam int TERMS  = 2 * NEIGHBOR_SPAN + 1;
    localparam int CNT_W  = $clog2(TERMS);
    localparam int SW     = ir_rbb_pkg::SAMPLE_W;
    localparam int Q_W    = ir_rbb_pkg::Q15_W;
    localparam int PROD_W = SW + 1 + Q_W;
    localparam int SUM_W  = PROD_W + $clog2(TERMS);
    localparam logic [AW-1:0]    LAST_POS  = AW'(NUM_SENSORS - 1);
    localparam logic [AW:0]      START_OFF = (AW+1)'(NUM_SENSORS - NEIGHBOR_SPAN);
    localparam logic [AW:0]      DEPTH_EXT = (AW+1)'(NUM_SENSORS);
    localparam logic [CNT_W-1:0] LAST_TERM = CNT_W'(TERMS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_START,
        S_WAIT,
        S_EMIT,
        S_NOBALL
    } state_t;

    state_t                  state_reg;
    logic [SW-1:0]           thr_reg;
    logic [AW-1:0]           pos_reg;
    logic [SW-1:0]           min_val_reg;
    logic [AW-1:0]           min_pos_reg;
    logic [AW-1:0]           rd_idx_reg;
    logic [CNT_W-1:0]        rd_cnt_reg;
    logic                    rd_vld_reg;
    logic [AW-1:0]           tab_idx_reg;
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic                    m_valid_reg;
    logic                    ball_reg;
    logic [ir_rbb_pkg::DEG_W-1:0]         deg_reg;
    logic signed [ir_rbb_pkg::DIST_W-1:0] dist_reg;

    logic                    in_acc;
    logic                    take_new;
    logic [SW-1:0]           min_val_next;
    logic [AW-1:0]           min_pos_next;
    logic [AW:0]             start_sum;
    logic [AW-1:0]           start_idx_next;
    logic [SW-1:0]           rd_data;
    logic signed [SW:0]      weight;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic                    out_free;
    logic                    m_load;
    logic                    polar_done;
    ir_rbb_pkg::polar_t      polar_res;
    logic signed [ir_rbb_pkg::MAG10_W:0]   dist_full;
    logic signed [ir_rbb_pkg::DIST_W-1:0]  dist_next;

    logic signed [Q_W-1:0]   cos_tab [NUM_SENSORS];
    logic signed [Q_W-1:0]   sin_tab [NUM_SENSORS];

    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_tab
        localparam longint ANG = (longint'(g) * ir_rbb_pkg::TURN_Q16) / NUM_SENSORS;
        assign {cos_tab[g], sin_tab[g]} = ir_rbb_pkg::unit_vec(ANG);
    end

    ir_rbb_sample_mem #(
        .DEPTH (NUM_SENSORS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (in_acc),
        .wr_addr (pos_reg),
        .wr_data (s_sensor_value),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    ir_rbb_polar #(
        .SUM_W (SUM_W)
    ) u_polar (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_START),
        .sum_x   (sum_x_reg),
        .sum_y   (sum_y_reg),
        .done    (polar_done),
        .result  (polar_res)
    );

    always_comb begin
        s_ready      = (state_reg == S_IDLE);
        cfg_ready    = 1'b1;
        in_acc       = s_valid && s_ready;
        take_new     = (pos_reg == '0) || (s_sensor_value < min_val_reg);
        min_val_next = take_new ? s_sensor_value : min_val_reg;
        min_pos_next = take_new ? pos_reg : min_pos_reg;
        start_sum    = {1'b0, min_pos_next} + START_OFF;
        start_idx_next = (start_sum >= DEPTH_EXT) ? AW'(start_sum - DEPTH_EXT)
                                                  : AW'(start_sum);
        weight       = signed'(ir_rbb_pkg::FULL_WEIGHT - {1'b0, rd_data});
        prod_x       = weight * cos_tab[tab_idx_reg];
        prod_y       = weight * sin_tab[tab_idx_reg];
        out_free     = !m_valid_reg || m_ready;
        m_load       = out_free && (state_reg == S_EMIT || state_reg == S_NOBALL);
        dist_full    = ir_rbb_pkg::DIST_BASE - signed'({1'b0, polar_res.mag10});
        dist_next    = (polar_res.mag10 > ir_rbb_pkg::DIST_LIMIT)
                       ? signed'(ir_rbb_pkg::DIST_FLOOR)
                       : ir_rbb_pkg::DIST_W'(dist_full);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            thr_reg     <= ir_rbb_pkg::THRESHOLD_RESET;
            pos_reg     <= '0;
            min_val_reg <= '0;
            min_pos_reg <= '0;
            rd_vld_reg  <= 1'b0;
            rd_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg  <= (state_reg == S_READ);
            tab_idx_reg <= rd_idx_reg;
            if (rd_vld_reg) begin
                sum_x_reg <= sum_x_reg + SUM_W'(prod_x);
                sum_y_reg <= sum_y_reg + SUM_W'(prod_y);
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        min_val_reg <= min_val_next;
                        min_pos_reg <= min_pos_next;
                        pos_reg     <= (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
                        if (pos_reg == LAST_POS) begin
                            if (min_val_next > thr_reg) begin
                                state_reg <= S_NOBALL;
                            end else begin
                                rd_idx_reg <= start_idx_next;
                                rd_cnt_reg <= '0;
                                sum_x_reg  <= '0;
                                sum_y_reg  <= '0;
                                state_reg  <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    rd_idx_reg <= (rd_idx_reg == LAST_POS) ? '0 : rd_idx_reg + 1'b1;
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (rd_cnt_reg == LAST_TERM) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    state_reg <= S_START;
                end
                S_START: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (polar_done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        ball_reg    <= 1'b1;
                        deg_reg     <= polar_res.deg;
                        dist_reg    <= dist_next;
                        state_reg   <= S_IDLE;
                    end
                end
                S_NOBALL: begin
                    if (out_free) begin
                        ball_reg    <= 1'b0;
                        deg_reg     <= '0;
                        dist_reg    <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ball_found  = ball_reg;
    assign m_bearing_deg = deg_reg;
    assign m_distance    = dist_reg;

    a_round_end_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && pos_reg == LAST_POS) |=> !s_ready)
        else $error("input taken right after round end");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == S_EMIT || $past(state_reg) == S_NOBALL))
        else $error("result appeared outside emit");

    a_no_ball_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ball_found) |-> (m_bearing_deg == '0 && m_distance == '0))
        else $error("no-ball result not zero");

    a_bearing_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bearing_deg <= ir_rbb_pkg::DEG_MAX))
        else $error("bearing out of range");

endmodule

@@ hdl/ir_rbb_sample_mem.sv @@
`timescale 1ns / 1ps

module ir_rbb_sample_mem #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [ir_rbb_pkg::SAMPLE_W-1:0]     wr_data,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [ir_rbb_pkg::SAMPLE_W-1:0]     rd_data
);

    logic [ir_rbb_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/ir_rbb_polar.sv @@
`timescale 1ns / 1ps

module ir_rbb_polar #(
    parameter int SUM_W = 30
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [SUM_W-1:0]    sum_x,
    input  logic signed [SUM_W-1:0]    sum_y,
    output logic                       done,
    output ir_rbb_pkg::polar_t         result
);

    localparam int X_W   = SUM_W + 7;
    localparam int LO_W  = 18;
    localparam int HI_W  = X_W - LO_W;
    localparam int G_W   = ir_rbb_pkg::GAIN_W;
    localparam int ACC_W = X_W + G_W;
    localparam int P_W   = ACC_W - ir_rbb_pkg::MAG_SHIFT;
    localparam int Q_W   = P_W + ir_rbb_pkg::RECIP_W;
    localparam int Z_W   = ir_rbb_pkg::Z_W;
    localparam int SW    = ir_rbb_pkg::STEP_W;
    localparam int DEG_SHIFT = ir_rbb_pkg::DEG_FRAC;
    localparam logic signed [Z_W-1:0] TURN_Z = Z_W'(ir_rbb_pkg::TURN_Q16);
    localparam logic signed [Z_W-1:0] HALF_Z = Z_W'(ir_rbb_pkg::HALF_Q16);
    localparam logic [SW-1:0] LAST_STEP = SW'(ir_rbb_pkg::CORDIC_STEPS - 1);

    typedef enum logic [2:0] {
        P_IDLE,
        P_ITER,
        P_NORM,
        P_MUL_HI,
        P_RECIP,
        P_FINISH
    } pstate_t;

    pstate_t                  state_reg;
    logic [SW-1:0]            step_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [X_W-1:0]    y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [Q_W-1:0]           q_reg;
    logic                     done_reg;
    ir_rbb_pkg::polar_t       result_reg;

    logic signed [X_W-1:0]    sx_ext;
    logic signed [X_W-1:0]    sy_ext;
    logic signed [X_W-1:0]    dx;
    logic signed [X_W-1:0]    dy;
    logic signed [Z_W-1:0]    z_step;
    logic signed [Z_W-1:0]    z_norm;
    logic [Z_W-DEG_SHIFT-1:0] deg_raw;
    logic [X_W-1:0]           x_mag;
    logic [LO_W+G_W-1:0]      prod_lo;
    logic [HI_W+G_W-1:0]      prod_hi;
    logic [Q_W-1:0]           q_prod;

    always_comb begin
        sx_ext  = X_W'(sum_x);
        sy_ext  = X_W'(sum_y);
        dx      = y_reg >>> step_reg;
        dy      = x_reg >>> step_reg;
        z_step  = signed'(Z_W'(ir_rbb_pkg::atan_q16(step_reg)));
        if (z_reg < 0) begin
            z_norm = z_reg + TURN_Z;
        end else if (z_reg >= TURN_Z) begin
            z_norm = z_reg - TURN_Z;
        end else begin
            z_norm = z_reg;
        end
        deg_raw = z_norm[Z_W-1:DEG_SHIFT];
        x_mag   = x_reg[X_W-1] ? '0 : x_reg;
        prod_lo = x_mag[LO_W-1:0] * ir_rbb_pkg::GAIN_Q30;
        prod_hi = x_mag[X_W-1:LO_W] * ir_rbb_pkg::GAIN_Q30;
        q_prod  = acc_reg[ir_rbb_pkg::MAG_SHIFT +: P_W] * ir_rbb_pkg::RECIP_TEN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE: begin
                    if (start) begin
                        if (sum_x == '0 && sum_y == '0) begin
                            result_reg.deg   <= '0;
                            result_reg.mag10 <= '0;
                            done_reg         <= 1'b1;
                        end else begin
                            if (sum_x < 0) begin
                                x_reg <= (-sx_ext) <<< 4;
                                y_reg <= (-sy_ext) <<< 4;
                                z_reg <= HALF_Z;
                            end else begin
                                x_reg <= sx_ext <<< 4;
                                y_reg <= sy_ext <<< 4;
                                z_reg <= '0;
                            end
                            step_reg  <= '0;
                            state_reg <= P_ITER;
                        end
                    end
                end
                P_ITER: begin
                    if (y_reg > 0) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + z_step;
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - z_step;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP) begin
                        state_reg <= P_NORM;
                    end
                end
                P_NORM: begin
                    result_reg.deg <= (deg_raw > (Z_W-DEG_SHIFT)'(ir_rbb_pkg::DEG_MAX))
                                      ? ir_rbb_pkg::DEG_MAX
                                      : ir_rbb_pkg::DEG_W'(deg_raw);
                    acc_reg   <= ACC_W'(prod_lo);
                    state_reg <= P_MUL_HI;
                end
                P_MUL_HI: begin
                    acc_reg   <= acc_reg + {prod_hi, LO_W'(0)};
                    state_reg <= P_RECIP;
                end
                P_RECIP: begin
                    q_reg     <= q_prod;
                    state_reg <= P_FINISH;
                end
                P_FINISH: begin
                    result_reg.mag10 <= q_reg[ir_rbb_pkg::RECIP_SHIFT +: ir_rbb_pkg::MAG10_W];
                    done_reg         <= 1'b1;
                    state_reg        <= P_IDLE;
                end
                default: begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int NSENS = 16;
    localparam int SPAN = 3;
    localparam int WAIT_MAX = 400000;
    localparam int FINAL_WAIT = 200;
    localparam longint ATAN_TAB [ir_rbb_pkg::CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    typedef struct {
        logic                          found;
        logic [ir_rbb_pkg::DEG_W-1:0]  deg;
        logic [ir_rbb_pkg::DIST_W-1:0] dist_val;
    } bearing_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ir_rbb_pkg::SAMPLE_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ir_rbb_pkg::SAMPLE_W-1:0] s_sensor_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_ball_found;
    logic [ir_rbb_pkg::DEG_W-1:0] m_bearing_deg;
    logic signed [ir_rbb_pkg::DIST_W-1:0] m_distance;

    ir_ring_ball_bearing_estimator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_sensor_value(s_sensor_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_ball_found(m_ball_found),
        .m_bearing_deg(m_bearing_deg), .m_distance(m_distance)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic [ir_rbb_pkg::SAMPLE_W-1:0] sample_q[$];
    bearing_t bearing_q[$];
    int send_idle = 35;
    int recv_idle = 82;
    int errors = 0;
    int results_seen = 0;
    int found_seen = 0;
    longint cycles = 0;
    logic s_taken = 1'b0;
    logic cfg_pending = 1'b0;
    logic [ir_rbb_pkg::SAMPLE_W-1:0] cfg_pending_data;

    logic [ir_rbb_pkg::SAMPLE_W-1:0] threshold;
    logic [ir_rbb_pkg::SAMPLE_W-1:0] ring [NSENS];
    int ring_pos;
    logic [ir_rbb_pkg::SAMPLE_W-1:0] ring_min;
    int ring_min_pos;
    longint cos_q15 [NSENS];
    longint sin_q15 [NSENS];

    function automatic longint round_q15(longint v);
        longint t;
        t = (v + 16384) >>> 15;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t;
    endfunction

    task automatic build_unit_vectors();
        longint ang, q, r, x, y, z, dx, dy, cc, ss;
        for (int k = 0; k < NSENS; k++) begin
            ang = (longint'(k) * 23592960) / NSENS;
            q = (ang / 5898240) % 4;
            r = ang % 5898240;
            cc = 32767;
            ss = 0;
            if (r != 0) begin
                x = 652032874;
                y = 0;
                z = r;
                for (int i = 0; i < ir_rbb_pkg::CORDIC_STEPS; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0) begin
                        x -= dx; y += dy; z -= ATAN_TAB[i];
                    end else begin
                        x += dx; y -= dy; z += ATAN_TAB[i];
                    end
                end
                cc = round_q15(x);
                ss = round_q15(y);
            end
            case (q)
                0: begin cos_q15[k] = cc; sin_q15[k] = ss; end
                1: begin cos_q15[k] = -ss; sin_q15[k] = cc; end
                2: begin cos_q15[k] = -cc; sin_q15[k] = -ss; end
                default: begin cos_q15[k] = ss; sin_q15[k] = -cc; end
            endcase
        end
    endtask

    task automatic predict_bearing(logic [ir_rbb_pkg::SAMPLE_W-1:0] v);
        bearing_t b;
        longint sx, sy, x, y, z, dx, dy, w, mag10, deg;
        int idx;
        ring[ring_pos] = v;
        if (ring_pos == 0 || v < ring_min) begin
            ring_min = v;
            ring_min_pos = ring_pos;
        end
        ring_pos++;
        if (ring_pos < NSENS) return;
        ring_pos = 0;
        b.found = 1'b0;
        b.deg = '0;
        b.dist_val = '0;
        if (ring_min <= threshold) begin
            sx = 0;
            sy = 0;
            for (int d = -SPAN; d <= SPAN; d++) begin
                idx = (ring_min_pos + d + NSENS) % NSENS;
                w = 1023 - longint'(ring[idx]);
                sx += w * cos_q15[idx];
                sy += w * sin_q15[idx];
            end
            deg = 0;
            mag10 = 0;
            if (sx != 0 || sy != 0) begin
                x = sx; y = sy; z = 0;
                if (x < 0) begin
                    x = -x; y = -y; z = 11796480;
                end
                x *= 16;
                y *= 16;
                for (int i = 0; i < ir_rbb_pkg::CORDIC_STEPS; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y > 0) begin
                        x += dx; y -= dy; z += ATAN_TAB[i];
                    end else begin
                        x -= dx; y += dy; z -= ATAN_TAB[i];
                    end
                end
                while (z < 0) z += 23592960;
                while (z >= 23592960) z -= 23592960;
                deg = z >>> 16;
                if (deg > 359) deg = 359;
                if (x < 0) x = 0;
                mag10 = ((x * 652032874) >>> 49) / 10;
            end
            b.found = 1'b1;
            b.deg = ir_rbb_pkg::DEG_W'(deg);
            b.dist_val = (mag10 > 1012) ? ir_rbb_pkg::DIST_W'(-512)
                                        : ir_rbb_pkg::DIST_W'(500 - mag10);
        end
        bearing_q.push_back(b);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want,
            results_seen);
        errors++;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > WAIT_MAX * 10) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken) begin
                void'(sample_q.pop_front());
            end
            if (!s_valid || s_taken) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_valid <= 1'b1;
                    s_sensor_value <= sample_q[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
            if (cfg_valid && cfg_ready) begin
                cfg_valid <= 1'b0;
            end else if (cfg_pending && !cfg_valid) begin
                cfg_valid <= 1'b1;
                cfg_data <= cfg_pending_data;
            end
        end
    end

    always @(posedge aclk) begin
        bearing_t b;
        if (aresetn) begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) predict_bearing(s_sensor_value);
            if (cfg_valid && cfg_ready) begin
                threshold = cfg_data;
                cfg_pending <= 1'b0;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (bearing_q.size() == 0) begin
                    report_mismatch("unexpected result", m_ball_found, -1);
                end else begin
                    b = bearing_q.pop_front();
                    if (b.found) found_seen++;
                    if (m_ball_found !== b.found)
                        report_mismatch("ball_found", m_ball_found, b.found);
                    if (m_bearing_deg !== b.deg)
                        report_mismatch("bearing_deg", m_bearing_deg, b.deg);
                    if (m_distance !== $signed(b.dist_val))
                        report_mismatch("distance", m_distance, $signed(b.dist_val));
                end
            end
        end
    end

    task automatic wait_drained();
        int n;
        n = 0;
        while ((sample_q.size() > 0 || s_valid || bearing_q.size() > 0) && n < WAIT_MAX) begin
            @(posedge aclk);
            n++;
        end
        if (n >= WAIT_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        repeat (FINAL_WAIT) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [ir_rbb_pkg::SAMPLE_W-1:0] t);
        wait_drained();
        cfg_pending_data = t;
        cfg_pending = 1'b1;
        while (cfg_pending) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic push_round(int mode);
        int mpos, mval;
        mpos = $urandom_range(NSENS - 1);
        mval = $urandom_range(1023);
        for (int k = 0; k < NSENS; k++) begin
            case (mode)
                0: sample_q.push_back(ir_rbb_pkg::SAMPLE_W'($urandom_range(1023)));
                1: sample_q.push_back(k == mpos ? ir_rbb_pkg::SAMPLE_W'(mval)
                    : ir_rbb_pkg::SAMPLE_W'($urandom_range(1023, mval)));
                default: sample_q.push_back(k == mpos
                    ? ir_rbb_pkg::SAMPLE_W'($urandom_range(300))
                    : ir_rbb_pkg::SAMPLE_W'($urandom_range(1023, 700)));
            endcase
        end
    endtask

    initial begin
        threshold = ir_rbb_pkg::THRESHOLD_RESET;
        ring_pos = 0;
        ring_min = '0;
        ring_min_pos = 0;
        foreach (ring[k]) ring[k] = '0;
        build_unit_vectors();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all zero, minimum at and just above the reset threshold, equal minimum ties, wraparound
        repeat (NSENS) sample_q.push_back(10'd0);
        for (int k = 0; k < NSENS; k++) sample_q.push_back(k == 0 ? 10'd1000 : 10'd1023);
        for (int k = 0; k < NSENS; k++) sample_q.push_back(k == 0 ? 10'd1001 : 10'd1023);
        for (int k = 0; k < NSENS; k++) sample_q.push_back((k == 3 || k == 9) ? 10'd5 : 10'd600);
        for (int k = 0; k < NSENS; k++) sample_q.push_back(k == 15 ? 10'd0 : 10'd1023);
        for (int k = 0; k < NSENS; k++) sample_q.push_back((k % 8 == 0) ? 10'd0 : 10'd1023);
        write_threshold(10'd0);
        for (int k = 0; k < NSENS; k++) sample_q.push_back(k == 4 ? 10'd0 : 10'd1);
        for (int k = 0; k < NSENS; k++) sample_q.push_back(k == 4 ? 10'd1 : 10'd2);
        write_threshold(10'd1023);
        repeat (NSENS) sample_q.push_back(10'd1023);
        repeat (NSENS) sample_q.push_back(10'h2AA);
        repeat (NSENS) sample_q.push_back(10'h155);

        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            send_idle = (phase == 0) ? 35 : (phase == 1) ? 82 : 0;
            recv_idle = (phase == 0) ? 82 : (phase == 1) ? 35 : 0;
            write_threshold(ir_rbb_pkg::SAMPLE_W'(phase == 2 ? $urandom_range(1023)
                : phase == 1 ? 500 : 1023));
            for (int r = 0; r < 9; r++) push_round($urandom_range(2));
        end
        wait_drained();
        $display("covered %0d results, %0d with a ball, threshold extremes and ties",
            results_seen, found_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
